// ===== rtl/core/slb_pkg.sv =====
package slb_pkg;

    localparam int OFFSET_BITS_DEF = 16;
    localparam int KEYWORD_MAX_DEF = 6;

    // token queue between the scanner and the output port
    localparam int TQ_DEPTH = 8;
    localparam int TQ_PTR_W = $clog2(TQ_DEPTH);
    localparam int TQ_CNT_W = TQ_PTR_W + 1;
    localparam int MAX_PUSH = 3;

    typedef enum logic [3:0] {
        M_IDLE    = 4'd0,
        M_SLASH   = 4'd1,
        M_COMMENT = 4'd2,
        M_OP      = 4'd3,
        M_NUM     = 4'd4,
        M_NUMDOT  = 4'd5,
        M_FRAC    = 4'd6,
        M_IDENT   = 4'd7,
        M_STRING  = 4'd8
    } scan_mode_t;

    localparam logic [5:0] K_LPAREN = 6'd0;
    localparam logic [5:0] K_RPAREN = 6'd1;
    localparam logic [5:0] K_LBRACE = 6'd2;
    localparam logic [5:0] K_RBRACE = 6'd3;
    localparam logic [5:0] K_SEMI   = 6'd4;
    localparam logic [5:0] K_COMMA  = 6'd5;
    localparam logic [5:0] K_DOT    = 6'd6;
    localparam logic [5:0] K_MINUS  = 6'd7;
    localparam logic [5:0] K_PLUS   = 6'd8;
    localparam logic [5:0] K_STAR   = 6'd9;
    localparam logic [5:0] K_SLASH  = 6'd10;
    localparam logic [5:0] K_BANG   = 6'd11;
    localparam logic [5:0] K_EQUAL  = 6'd13;
    localparam logic [5:0] K_LESS   = 6'd15;
    localparam logic [5:0] K_GREATER = 6'd17;
    localparam logic [5:0] K_STRING = 6'd19;
    localparam logic [5:0] K_NUMBER = 6'd20;
    localparam logic [5:0] K_BIGINT = 6'd21;
    localparam logic [5:0] K_IDENT  = 6'd22;
    localparam logic [5:0] K_KEY0   = 6'd23;
    localparam logic [5:0] K_ERROR  = 6'd41;
    localparam logic [5:0] K_EOF    = 6'd42;

    localparam logic [1:0] E_NONE       = 2'd0;
    localparam logic [1:0] E_UNEXPECTED = 2'd1;
    localparam logic [1:0] E_UNTERM_STR = 2'd2;

    localparam int NKEYS = 18;
    localparam int KW_BYTES = 6;

    // keyword text, first character in the top byte
    localparam logic [NKEYS-1:0][47:0] KW_TEXT = '{
        {"while", 8'd0},
        {"var", 24'd0},
        {"true", 16'd0},
        {"this", 16'd0},
        {"super", 8'd0},
        "return",
        {"print", 8'd0},
        {"or", 32'd0},
        {"null", 16'd0},
        {"let", 24'd0},
        {"if", 32'd0},
        {"fun", 24'd0},
        {"for", 24'd0},
        {"false", 8'd0},
        {"else", 16'd0},
        {"const", 8'd0},
        {"class", 8'd0},
        {"and", 24'd0}
    };

    localparam logic [NKEYS-1:0][3:0] KW_LEN = '{
        4'd5, 4'd3, 4'd4, 4'd4, 4'd5, 4'd6, 4'd5, 4'd2, 4'd4,
        4'd3, 4'd2, 4'd3, 4'd3, 4'd5, 4'd4, 4'd5, 4'd5, 4'd3
    };

    typedef struct packed {
        logic [5:0]  kind;
        logic [1:0]  err;
        logic [15:0] start;
        logic [15:0] len;
        logic [15:0] line;
        logic        last;
    } token_t;

    function automatic logic is_digit(logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        logic [7:0] lc;
        lc = c | 8'h20;
        return ((lc >= "a") && (lc <= "z")) || (c == "_");
    endfunction

    // w[i] holds word byte i; len is the word length (1..6)
    function automatic logic [5:0] kw_kind(logic [KW_BYTES-1:0][7:0] w, logic [3:0] len);
        logic [5:0] k;
        logic       hit;
        k = K_IDENT;
        for (int j = NKEYS - 1; j >= 0; j--) begin
            hit = (len == KW_LEN[j]);
            for (int i = 0; i < KW_BYTES; i++) begin
                if (4'(i) < KW_LEN[j] && w[i] != KW_TEXT[j][47 - 8*i -: 8])
                    hit = 1'b0;
            end
            if (hit)
                k = K_KEY0 + 6'(j);
        end
        return k;
    endfunction

    function automatic logic [5:0] op_kind(logic [7:0] c);
        logic [5:0] k;
        case (c)
            "!":     k = K_BANG;
            "=":     k = K_EQUAL;
            "<":     k = K_LESS;
            default: k = K_GREATER;
        endcase
        return k;
    endfunction

endpackage

// ===== rtl/core/slb_token_queue.sv =====
module slb_token_queue (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [1:0]                push_n,
    input  slb_pkg::token_t           push_tok [slb_pkg::MAX_PUSH],
    output logic                      almost_full,
    output logic                      valid,
    input  logic                      stall,
    output slb_pkg::token_t           head
);
    import slb_pkg::*;

    token_t                q_reg [TQ_DEPTH];
    logic [TQ_PTR_W-1:0]   rd_reg, rd_next;
    logic [TQ_PTR_W-1:0]   wr_reg, wr_next;
    logic [TQ_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                  pop;

    assign valid = (cnt_reg != '0);
    assign head  = q_reg[rd_reg];
    assign pop   = valid && !stall;
    // room for a byte in flight plus the one being accepted
    assign almost_full = (cnt_reg > TQ_CNT_W'(TQ_DEPTH - 2 * MAX_PUSH));

    always_comb
    begin
        rd_next  = rd_reg + TQ_PTR_W'(pop);
        wr_next  = wr_reg + TQ_PTR_W'(push_n);
        cnt_next = cnt_reg + TQ_CNT_W'(push_n) - TQ_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= '0;
            wr_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_PUSH; i++)
        begin
            if (2'(i) < push_n)
                q_reg[wr_reg + TQ_PTR_W'(i)] <= push_tok[i];
        end
    end

endmodule

// ===== rtl/core/script_lexer_byte_stream.sv =====
// Byte-stream lexer for a small scripting language.
// Source channel: src_valid/src_stall with source_byte, one byte per
// transaction; a zero byte ends the source. Token channel: tok_valid/tok_stall
// with token_kind, error_kind, start_offset, token_bytes, line_number, last.
// Each byte is registered, then scanned in the next cycle, and the tokens it
// completes (up to three) are written into an 8-entry token queue, so the
// first token of a byte passes the input byte register and then a queue entry
// before it is valid on the token port. Throughput is one byte per cycle while
// src_stall is low; the queue drains one token per cycle while tok_stall is
// low. The eof token carries last = 1 and the scanner returns to its reset
// state, ready for the next source in the following cycle.
// src_stall rises when the token queue has fewer free entries than two bytes
// can fill (three or more tokens queued), so a stalled token port backs up
// into the source; no token is dropped. Reset clears the scanner state
// (offset 0, line 1) and empties the queue.
module script_lexer_byte_stream #(
    parameter int OFFSET_BITS = slb_pkg::OFFSET_BITS_DEF,
    parameter int KEYWORD_MAX = slb_pkg::KEYWORD_MAX_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        src_valid,
    output logic        src_stall,
    input  logic [7:0]  source_byte,
    output logic        tok_valid,
    input  logic        tok_stall,
    output logic [5:0]  token_kind,
    output logic [1:0]  error_kind,
    output logic [15:0] start_offset,
    output logic [15:0] token_bytes,
    output logic [15:0] line_number,
    output logic        last
);
    import slb_pkg::*;

    localparam int OB = OFFSET_BITS;
    localparam int IW = $clog2(KEYWORD_MAX);

    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    scan_mode_t        mode_reg, mode_next;
    logic [OB-1:0]     start_reg, start_next;
    logic [OB-1:0]     off_reg, off_next;
    logic [15:0]       line_reg, line_next;
    logic [7:0]        pend_reg, pend_next;
    logic [7:0]        wbuf_reg [KEYWORD_MAX];

    logic              wb_we;
    logic [IW-1:0]     wb_idx;
    logic [1:0]        push_n;
    token_t            push_tok [MAX_PUSH];
    logic              almost_full;
    token_t            head;
    logic              accept;

    logic [KW_BYTES-1:0][7:0] word;

    function automatic logic [15:0] lo16(logic [OB:0] v);
        logic [32:0] w;
        w = 33'(v);
        return w[15:0];
    endfunction

    function automatic token_t mk_tok(logic [5:0] kind, logic [1:0] err,
                                      logic [OB:0] s, logic [OB:0] e,
                                      logic lst, logic [15:0] line);
        token_t      t;
        logic [OB:0] d;
        logic [32:0] w;
        d = (e > s) ? e - s : '0;
        w = 33'(d);
        t.kind  = kind;
        t.err   = err;
        t.start = lo16(s);
        t.len   = (w > 33'h0FFFF) ? 16'hFFFF : w[15:0];
        t.line  = line;
        t.last  = lst;
        return t;
    endfunction

    assign accept    = src_valid && !src_stall;
    assign src_stall = almost_full;

    always_comb
    begin
        for (int i = 0; i < KW_BYTES; i++)
            word[i] = wbuf_reg[i];
    end

    always_comb
    begin
        logic [7:0]  c;
        logic [OB:0] off, st, off1, dot, diff;
        logic        used;
        logic        a_v, b_v, c_v, rst_scan;
        token_t      a_t, b_t, c_t;

        c    = in_byte_reg;
        off  = {1'b0, off_reg};
        st   = {1'b0, start_reg};
        off1 = off + 1'b1;
        dot  = (off != '0) ? off - 1'b1 : '0;
        diff = off - st;
        used = 1'b0;
        a_v  = 1'b0;
        b_v  = 1'b0;
        c_v  = 1'b0;
        a_t  = '0;
        b_t  = '0;
        c_t  = '0;
        rst_scan = 1'b0;

        mode_next  = mode_reg;
        start_next = start_reg;
        off_next   = off_reg;
        line_next  = line_reg;
        pend_next  = pend_reg;
        wb_we      = 1'b0;
        wb_idx     = diff[IW-1:0];

        if (in_valid_reg)
        begin
            case (mode_reg)
                M_SLASH:
                begin
                    if (c == "/")
                    begin
                        mode_next = M_COMMENT;
                        used = 1'b1;
                    end
                    else
                    begin
                        a_v = 1'b1;
                        a_t = mk_tok(K_SLASH, E_NONE, st, off, 1'b0, line_reg);
                    end
                end
                M_COMMENT:
                    used = (c != 8'h0A) && (c != 8'h00);
                M_OP:
                begin
                    a_v = 1'b1;
                    if (c == "=")
                    begin
                        a_t = mk_tok(op_kind(pend_reg) + 6'd1, E_NONE, st, off1, 1'b0,
                                     line_reg);
                        used = 1'b1;
                        mode_next = M_IDLE;
                    end
                    else
                        a_t = mk_tok(op_kind(pend_reg), E_NONE, st, off, 1'b0, line_reg);
                end
                M_NUM:
                begin
                    if (is_digit(c))
                        used = 1'b1;
                    else if (c == ".")
                    begin
                        mode_next = M_NUMDOT;
                        used = 1'b1;
                    end
                    else if (c == "n")
                    begin
                        a_v = 1'b1;
                        a_t = mk_tok(K_BIGINT, E_NONE, st, off1, 1'b0, line_reg);
                        used = 1'b1;
                        mode_next = M_IDLE;
                    end
                    else
                    begin
                        a_v = 1'b1;
                        a_t = mk_tok(K_NUMBER, E_NONE, st, off, 1'b0, line_reg);
                    end
                end
                M_NUMDOT:
                begin
                    if (is_digit(c))
                    begin
                        mode_next = M_FRAC;
                        used = 1'b1;
                    end
                    else
                    begin
                        // number and the held dot as separate tokens
                        a_v = 1'b1;
                        b_v = 1'b1;
                        a_t = mk_tok(K_NUMBER, E_NONE, st, dot, 1'b0, line_reg);
                        b_t = mk_tok(K_DOT, E_NONE, dot, dot + 1'b1, 1'b0, line_reg);
                    end
                end
                M_FRAC:
                begin
                    if (is_digit(c))
                        used = 1'b1;
                    else
                    begin
                        a_v = 1'b1;
                        a_t = mk_tok(K_NUMBER, E_NONE, st, off, 1'b0, line_reg);
                    end
                end
                M_IDENT:
                begin
                    if (is_alpha(c) || is_digit(c))
                    begin
                        wb_we = (diff < (OB+1)'(KEYWORD_MAX));
                        used = 1'b1;
                    end
                    else
                    begin
                        a_v = 1'b1;
                        a_t = mk_tok((diff > (OB+1)'(KW_BYTES)) ? K_IDENT :
                                     kw_kind(word, diff[3:0]),
                                     E_NONE, st, off, 1'b0, line_reg);
                    end
                end
                M_STRING:
                begin
                    if (c == "\"")
                    begin
                        a_v = 1'b1;
                        a_t = mk_tok(K_STRING, E_NONE, st, off1, 1'b0, line_reg);
                        used = 1'b1;
                        mode_next = M_IDLE;
                    end
                    else if (c == 8'h00)
                    begin
                        a_v = 1'b1;
                        a_t = mk_tok(K_ERROR, E_UNTERM_STR, st, st, 1'b0, line_reg);
                    end
                    else
                    begin
                        if (c == 8'h0A && line_reg != 16'hFFFF)
                            line_next = line_reg + 16'd1;
                        used = 1'b1;
                    end
                end
                default:
                    used = 1'b0;
            endcase

            if (!used)
            begin
                mode_next = M_IDLE;
                if (c == 8'h00)
                begin
                    c_v = 1'b1;
                    c_t = mk_tok(K_EOF, E_NONE, off, off, 1'b1, line_reg);
                    rst_scan = 1'b1;
                end
                else if (c == " " || c == 8'h0D || c == 8'h09)
                    c_v = 1'b0;
                else if (c == 8'h0A)
                begin
                    if (line_reg != 16'hFFFF)
                        line_next = line_reg + 16'd1;
                end
                else
                begin
                    case (c)
                        "(": begin c_v = 1'b1; c_t.kind = K_LPAREN; end
                        ")": begin c_v = 1'b1; c_t.kind = K_RPAREN; end
                        "{": begin c_v = 1'b1; c_t.kind = K_LBRACE; end
                        "}": begin c_v = 1'b1; c_t.kind = K_RBRACE; end
                        ";": begin c_v = 1'b1; c_t.kind = K_SEMI; end
                        ",": begin c_v = 1'b1; c_t.kind = K_COMMA; end
                        ".": begin c_v = 1'b1; c_t.kind = K_DOT; end
                        "-": begin c_v = 1'b1; c_t.kind = K_MINUS; end
                        "+": begin c_v = 1'b1; c_t.kind = K_PLUS; end
                        "*": begin c_v = 1'b1; c_t.kind = K_STAR; end
                        default: c_v = 1'b0;
                    endcase
                    if (c_v)
                        c_t = mk_tok(c_t.kind, E_NONE, off, off1, 1'b0, line_reg);
                    else
                    begin
                        start_next = off_reg;
                        if (c == "/")
                            mode_next = M_SLASH;
                        else if (c == "!" || c == "=" || c == "<" || c == ">")
                        begin
                            pend_next = c;
                            mode_next = M_OP;
                        end
                        else if (c == "\"")
                            mode_next = M_STRING;
                        else if (is_digit(c))
                            mode_next = M_NUM;
                        else if (is_alpha(c))
                        begin
                            wb_we  = 1'b1;
                            wb_idx = '0;
                            mode_next = M_IDENT;
                        end
                        else
                        begin
                            c_v = 1'b1;
                            c_t = mk_tok(K_ERROR, E_UNEXPECTED, off, off, 1'b0, line_reg);
                        end
                    end
                end
            end

            if (rst_scan)
            begin
                mode_next  = M_IDLE;
                start_next = '0;
                off_next   = '0;
                line_next  = 16'd1;
                pend_next  = '0;
            end
            else if (off_reg != '1)
                off_next = off_reg + 1'b1;
        end

        // pack mode tokens first, then the token of the new byte
        push_tok[0] = a_v ? a_t : c_t;
        push_tok[1] = b_v ? b_t : c_t;
        push_tok[2] = c_t;
        push_n = 2'(a_v) + 2'(b_v) + 2'(c_v);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            mode_reg     <= M_IDLE;
            start_reg    <= '0;
            off_reg      <= '0;
            line_reg     <= 16'd1;
            pend_reg     <= '0;
        end
        else
        begin
            in_valid_reg <= accept;
            mode_reg     <= mode_next;
            start_reg    <= start_next;
            off_reg      <= off_next;
            line_reg     <= line_next;
            pend_reg     <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_byte_reg <= source_byte;
        if (wb_we)
            wbuf_reg[wb_idx] <= in_byte_reg;
    end

    slb_token_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push_n      (push_n),
        .push_tok    (push_tok),
        .almost_full (almost_full),
        .valid       (tok_valid),
        .stall       (tok_stall),
        .head        (head)
    );

    assign token_kind   = head.kind;
    assign error_kind   = head.err;
    assign start_offset = head.start;
    assign token_bytes  = head.len;
    assign line_number  = head.line;
    assign last         = head.last;

endmodule

// ===== dv/tb_script_lexer_byte_stream.sv =====
module tb_script_lexer_byte_stream;
    import slb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic        clk;
    logic        rst_n;
    logic        src_valid;
    logic        src_stall;
    logic [7:0]  source_byte;
    logic        tok_valid;
    logic        tok_stall;
    logic [5:0]  token_kind;
    logic [1:0]  error_kind;
    logic [15:0] start_offset;
    logic [15:0] token_bytes;
    logic [15:0] line_number;
    logic        last;

    script_lexer_byte_stream u_dut (
        .clk(clk), .rst_n(rst_n),
        .src_valid(src_valid), .src_stall(src_stall), .source_byte(source_byte),
        .tok_valid(tok_valid), .tok_stall(tok_stall),
        .token_kind(token_kind), .error_kind(error_kind),
        .start_offset(start_offset), .token_bytes(token_bytes),
        .line_number(line_number), .last(last)
    );

    // scanner copy
    scan_mode_t     lx_mode;
    logic [15:0]    lx_start;
    logic [15:0]    lx_off;
    logic [15:0]    lx_line;
    logic [7:0]     lx_word [KEYWORD_MAX_DEF];
    logic [7:0]     lx_pend;

    token_t expected_tokens [$];
    int     mismatches;
    bit     hold_off;
    int     gap_max;

    const string kw_names [NKEYS] = '{"and", "class", "const", "else", "false",
        "for", "fun", "if", "let", "null", "or", "print", "return", "super",
        "this", "true", "var", "while"};

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #50ms;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic bit digit_char(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit word_char(logic [7:0] c);
        logic [7:0] lc;
        lc = c | 8'h20;
        return (lc >= "a" && lc <= "z") || c == "_";
    endfunction

    task automatic push_token(logic [5:0] kind, logic [1:0] err, logic [15:0] s,
                              logic [16:0] e, logic lst);
        token_t t;
        t.kind  = kind;
        t.err   = err;
        t.start = s;
        t.len   = (e > {1'b0, s}) ? ((e - s > 17'hFFFF) ? 16'hFFFF : 16'(e - s)) : 16'd0;
        t.line  = lx_line;
        t.last  = lst;
        expected_tokens.push_back(t);
    endtask

    function automatic logic [5:0] word_token(logic [16:0] len);
        string s;
        if (len > KEYWORD_MAX_DEF)
            return K_IDENT;
        s = "";
        for (int i = 0; i < len; i++)
            s = {s, string'(lx_word[i])};
        for (int k = 0; k < NKEYS; k++)
            if (s == kw_names[k])
                return K_KEY0 + 6'(k);
        return K_IDENT;
    endfunction

    function automatic logic [5:0] pend_kind(logic [7:0] c);
        case (c)
            "!": return K_BANG;
            "=": return K_EQUAL;
            "<": return K_LESS;
            default: return K_GREATER;
        endcase
    endfunction

    task automatic lexer_reset();
        lx_mode  = M_IDLE;
        lx_start = '0;
        lx_off   = '0;
        lx_line  = 16'd1;
        lx_pend  = '0;
        foreach (lx_word[i]) lx_word[i] = '0;
    endtask

    task automatic bump_line();
        if (lx_line != 16'hFFFF) lx_line++;
    endtask

    task automatic predict_byte(logic [7:0] c);
        logic [16:0] off;
        logic [15:0] dot;
        bit          used;
        off  = {1'b0, lx_off};
        used = 1'b0;
        case (lx_mode)
            M_SLASH:
                if (c == "/") begin lx_mode = M_COMMENT; used = 1; end
                else push_token(K_SLASH, E_NONE, lx_start, off, 0);
            M_COMMENT:
                if (c != "\n" && c != 0) used = 1;
            M_OP:
                if (c == "=") begin
                    push_token(pend_kind(lx_pend) + 6'd1, E_NONE, lx_start, off + 17'd1, 0);
                    used = 1;
                end else push_token(pend_kind(lx_pend), E_NONE, lx_start, off, 0);
            M_NUM:
                if (digit_char(c)) used = 1;
                else if (c == ".") begin lx_mode = M_NUMDOT; used = 1; end
                else if (c == "n") begin
                    push_token(K_BIGINT, E_NONE, lx_start, off + 17'd1, 0);
                    used = 1;
                end else push_token(K_NUMBER, E_NONE, lx_start, off, 0);
            M_NUMDOT:
                if (digit_char(c)) begin lx_mode = M_FRAC; used = 1; end
                else begin
                    dot = (lx_off > 0) ? lx_off - 16'd1 : 16'd0;
                    push_token(K_NUMBER, E_NONE, lx_start, {1'b0, dot}, 0);
                    push_token(K_DOT, E_NONE, dot, {1'b0, dot} + 17'd1, 0);
                end
            M_FRAC:
                if (digit_char(c)) used = 1;
                else push_token(K_NUMBER, E_NONE, lx_start, off, 0);
            M_IDENT:
                if (word_char(c) || digit_char(c)) begin
                    if (lx_off >= lx_start && lx_off - lx_start < KEYWORD_MAX_DEF)
                        lx_word[lx_off - lx_start] = c;
                    used = 1;
                end else
                    push_token(word_token(off - lx_start), E_NONE, lx_start, off, 0);
            M_STRING:
                if (c == "\"") begin
                    push_token(K_STRING, E_NONE, lx_start, off + 17'd1, 0);
                    used = 1;
                end else if (c == 0)
                    push_token(K_ERROR, E_UNTERM_STR, lx_start, {1'b0, lx_start}, 0);
                else begin
                    if (c == "\n") bump_line();
                    used = 1;
                end
            default: ;
        endcase

        if (used) begin
            if (!(lx_mode inside {M_COMMENT, M_NUMDOT, M_FRAC, M_NUM, M_IDENT, M_STRING}))
                lx_mode = M_IDLE;
            else if (lx_mode == M_NUM && c == "n")
                lx_mode = M_IDLE;
            else if (lx_mode == M_STRING && c == "\"")
                lx_mode = M_IDLE;
        end else begin
            lx_mode = M_IDLE;
            if (c == 0) begin
                push_token(K_EOF, E_NONE, lx_off, off, 1);
                lexer_reset();
                return;
            end
            case (c)
                "(": push_token(K_LPAREN, E_NONE, lx_off, off + 17'd1, 0);
                ")": push_token(K_RPAREN, E_NONE, lx_off, off + 17'd1, 0);
                "{": push_token(K_LBRACE, E_NONE, lx_off, off + 17'd1, 0);
                "}": push_token(K_RBRACE, E_NONE, lx_off, off + 17'd1, 0);
                ";": push_token(K_SEMI, E_NONE, lx_off, off + 17'd1, 0);
                ",": push_token(K_COMMA, E_NONE, lx_off, off + 17'd1, 0);
                ".": push_token(K_DOT, E_NONE, lx_off, off + 17'd1, 0);
                "-": push_token(K_MINUS, E_NONE, lx_off, off + 17'd1, 0);
                "+": push_token(K_PLUS, E_NONE, lx_off, off + 17'd1, 0);
                "*": push_token(K_STAR, E_NONE, lx_off, off + 17'd1, 0);
                " ", "\r", "\t": ;
                "\n": bump_line();
                default:
                begin
                    lx_start = lx_off;
                    if (c == "/") lx_mode = M_SLASH;
                    else if (c == "!" || c == "=" || c == "<" || c == ">") begin
                        lx_pend = c;
                        lx_mode = M_OP;
                    end else if (c == "\"") lx_mode = M_STRING;
                    else if (digit_char(c)) lx_mode = M_NUM;
                    else if (word_char(c)) begin
                        lx_word[0] = c;
                        lx_mode = M_IDENT;
                    end else push_token(K_ERROR, E_UNEXPECTED, lx_off, off, 0);
                end
            endcase
        end
        if (lx_off != 16'hFFFF) lx_off++;
    endtask

    // one byte per transaction; valid stays up across a burst, drops in a gap
    task automatic send_byte(logic [7:0] c);
        int gap;
        gap = (gap_max > 0 && $urandom_range(3) == 0) ? $urandom_range(1, gap_max) : 0;
        if (gap > 0) begin
            src_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        src_valid   <= 1'b1;
        source_byte <= c;
        @(posedge clk);
        while (src_stall) @(posedge clk);
        predict_byte(c);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic wait_drained();
        src_valid <= 1'b0;
        @(posedge clk);
        while (expected_tokens.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic string random_lexeme();
        case ($urandom_range(11))
            0, 11: return kw_names[$urandom_range(NKEYS - 1)];
            1: return $sformatf("%0d", $urandom_range(999));
            2: return $sformatf("%0d.%0d", $urandom_range(99), $urandom_range(9));
            3: return $sformatf("%0dn", $urandom_range(99));
            4: return "\"a c\"";
            5: return "//n\n";
            6: return "<=";
            7: return "!=";
            8: return "x_1";
            9: return "\n";
            default: return "(;-*/=>!";
        endcase
    endfunction

    task automatic test_directed();
        send_text("(){};,.-+*/! != = == < <= > >=");
        send_byte(8'd0);
        send_text("and return while whiles _A9 ");
        send_byte(8'd0);
        send_text("12 3.5 7n 4.n 8. 9.1n //c\n\"s\nt\" @\t");
        send_byte(8'd0);
        send_text("\"op");
        send_byte(8'd0);
        send_text("//");
        send_byte(8'd0);
        wait_drained();
    endtask

    task automatic test_random_streams();
        gap_max = 6;
        for (int i = 0; i < 5; i++) begin
            send_text(random_lexeme());
            send_byte(($urandom_range(1)) ? " " : 8'($urandom_range(1, 255)));
            if ($urandom_range(9) == 0) send_byte(8'd0);
        end
        send_byte(8'd0);
        wait_drained();
    endtask

    task automatic test_backpressure();
        gap_max = 0;
        hold_off = 1'b1;
        for (int i = 0; i < 10; i++)
            send_text("( ");
        send_byte(8'd0);
        wait_drained();
    endtask

    task automatic test_random_bytes();
        gap_max = 3;
        for (int i = 0; i < 8; i++)
            send_byte(8'($urandom_range(1, 255)));
        send_byte(8'd0);
        wait_drained();
    endtask

    // long stall on request, else a random pattern with calm stretches
    initial begin
        int phase;
        tok_stall = 1'b0;
        phase = 0;
        forever begin
            @(posedge clk);
            if (hold_off) begin
                tok_stall <= 1'b1;
                repeat (200) @(posedge clk);
                hold_off = 1'b0;
                tok_stall <= 1'b0;
            end else begin
                phase++;
                tok_stall <= (phase % 64 < 20) ? 1'b0 : ($urandom_range(3) == 0);
            end
        end
    end

    always @(posedge clk) begin
        token_t exp_t;
        if (rst_n && tok_valid && !tok_stall) begin
            if (expected_tokens.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected token kind=%0d start=%0d", token_kind, start_offset);
            end else begin
                exp_t = expected_tokens.pop_front();
                if (token_kind != exp_t.kind || error_kind != exp_t.err ||
                    start_offset != exp_t.start || token_bytes != exp_t.len ||
                    line_number != exp_t.line || last != exp_t.last) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch exp k%0d e%0d s%0d l%0d n%0d t%0d",
                            exp_t.kind, exp_t.err, exp_t.start, exp_t.len, exp_t.line,
                            exp_t.last);
                        $display("         got k%0d e%0d s%0d l%0d n%0d t%0d",
                            token_kind, error_kind, start_offset, token_bytes,
                            line_number, last);
                    end
                end
            end
        end
    end

    initial begin
        rst_n       = 1'b0;
        src_valid   = 1'b0;
        source_byte = '0;
        mismatches  = 0;
        hold_off    = 1'b0;
        gap_max     = 0;
        lexer_reset();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_random_streams();
        test_random_bytes();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && expected_tokens.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/slb_pkg.sv
rtl/core/slb_token_queue.sv
rtl/core/script_lexer_byte_stream.sv
dv/tb_script_lexer_byte_stream.sv
